>>> rtl/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, constants and character helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned BASE_W         = 6;
    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned STOP_W         = 16;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned DIGIT_W        = 6;
    localparam int unsigned INDEX_BITS_DEF = 16;

    localparam logic [BASE_W-1:0]  MAX_BASE   = 6'd36;
    localparam logic [BASE_W-1:0]  BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0]  BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0]  BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0]  BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0]  BASE_UNARY = 6'd1;
    localparam logic [DIGIT_W-1:0] NO_DIGIT   = 6'd36;
    localparam logic [VALUE_W-1:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_START  = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_XSEEN  = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [VALUE_W-1:0]  acc;
        logic [BASE_W-1:0]   base;
        logic                neg;
        logic                ovf;
    } t_pstate;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               neg;
        logic [STOP_W-1:0]  stop_index;
        t_status            status;
    } t_result;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
        end else if (c inside {[8'h61:8'h7a]}) begin
            t = c - 8'h57;
        end else if (c inside {[8'h41:8'h5a]}) begin
            t = c - 8'h37;
        end else begin
            t = {2'b00, NO_DIGIT};
        end
        return t[DIGIT_W-1:0];
    endfunction

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

endpackage

>>> rtl/aip_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_char_if
// Character channel: one string byte per beat with an end-of-string mark.
// ----------------------------------------------------------------------------
interface aip_char_if;
    logic                         valid;
    logic                         ready;
    logic [aip_pkg::CHAR_W-1:0]   char_code;
    logic                         is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

>>> rtl/aip_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_res_if
// Result channel: parsed value, stop position and status per beat.
// ----------------------------------------------------------------------------
interface aip_res_if;
    logic                           valid;
    logic                           ready;
    logic [aip_pkg::VALUE_W-1:0]    value;
    logic [aip_pkg::STOP_W-1:0]     stop_index;
    logic [aip_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output value, output stop_index, output status,
                    input ready);
    modport sink   (input valid, input value, input stop_index, input status,
                    output ready);
endinterface

>>> rtl/aip_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_cfg_if
// Configuration write channel for the number base register.
// ----------------------------------------------------------------------------
interface aip_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [aip_pkg::BASE_W-1:0]   number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

>>> rtl/aip_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_step
// Per-byte parse step: prefix and sign handling, digit multiply-accumulate
// with exact overflow detection, and result formation at end of string.
// ----------------------------------------------------------------------------
module aip_step #(
    parameter int unsigned INDEX_BITS = aip_pkg::INDEX_BITS_DEF
) (
    input  logic [aip_pkg::BASE_W-1:0]  i_cfg_base,
    input  aip_pkg::t_pstate            i_state,
    input  logic [((INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                   : aip_pkg::STOP_W)-1:0] i_pos,
    input  logic [((INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                   : aip_pkg::STOP_W)-1:0] i_stop,
    input  logic [aip_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output aip_pkg::t_pstate            o_state,
    output logic [((INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                   : aip_pkg::STOP_W)-1:0] o_pos,
    output logic [((INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                   : aip_pkg::STOP_W)-1:0] o_stop,
    output aip_pkg::t_result            o_result
);

    localparam int unsigned POS_W = (INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                                                                   : aip_pkg::STOP_W;
    localparam int unsigned PROD_W = aip_pkg::VALUE_W + aip_pkg::BASE_W;

    logic [aip_pkg::BASE_W-1:0]   base_eff;
    logic [aip_pkg::BASE_W-1:0]   tb;
    logic [aip_pkg::DIGIT_W-1:0]  dig;
    logic                         bad;
    logic                         start;
    logic                         take;
    aip_pkg::t_phase              phase_eff;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W:0]              wide;
    logic [POS_W-1:0]             pos_inc;
    aip_pkg::t_pstate             n_st;
    logic [POS_W-1:0]             n_stop;

    assign dig     = aip_pkg::digit_of(i_char);
    assign pos_inc = (i_pos == {POS_W{1'b1}}) ? i_pos : i_pos + 1'b1;
    assign prod    = PROD_W'(i_state.acc) * PROD_W'(tb);
    assign wide    = {1'b0, prod} + (PROD_W + 1)'(dig);

    always_comb begin
        base_eff  = ((i_pos == '0) && (i_state.phase == aip_pkg::PH_SPACE)) ? i_cfg_base
                                                                            : i_state.base;
        bad       = (base_eff == aip_pkg::BASE_UNARY) || (base_eff > aip_pkg::MAX_BASE);
        phase_eff = bad ? aip_pkg::PH_DONE : i_state.phase;
        n_st      = i_state;
        n_st.base = base_eff;
        n_stop    = i_stop;
        start     = 1'b0;
        take      = 1'b0;
        tb        = base_eff;

        case (phase_eff)
            aip_pkg::PH_SPACE: begin
                if (aip_pkg::is_white(i_char)) begin
                    n_st.phase = aip_pkg::PH_SPACE;
                end else if ((i_char == aip_pkg::CH_PLUS) || (i_char == aip_pkg::CH_MINUS)) begin
                    n_st.neg   = (i_char == aip_pkg::CH_MINUS);
                    n_st.phase = aip_pkg::PH_START;
                end else begin
                    start = 1'b1;
                end
            end
            aip_pkg::PH_START: begin
                start = 1'b1;
            end
            aip_pkg::PH_ZERO: begin
                if ((i_char == aip_pkg::CH_LOW_X) || (i_char == aip_pkg::CH_UP_X)) begin
                    n_st.phase = aip_pkg::PH_XSEEN;
                end else begin
                    take = 1'b1;
                    tb   = (base_eff == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT : base_eff;
                end
            end
            aip_pkg::PH_XSEEN: begin
                take = 1'b1;
                tb   = aip_pkg::BASE_HEX;
            end
            aip_pkg::PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
                n_st.phase = aip_pkg::PH_DONE;
            end
        endcase

        if (start) begin
            if (((base_eff == aip_pkg::BASE_AUTO) || (base_eff == aip_pkg::BASE_HEX))
                && (i_char == aip_pkg::CH_ZERO)) begin
                n_st.acc   = '0;
                n_stop     = pos_inc;
                n_st.phase = aip_pkg::PH_ZERO;
            end else begin
                take = 1'b1;
                tb   = (base_eff == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : base_eff;
            end
        end

        if (take) begin
            n_st.base = tb;
            if (dig < tb) begin
                if (!i_state.ovf) begin
                    if (wide[PROD_W:aip_pkg::VALUE_W] != '0) begin
                        n_st.ovf = 1'b1;
                    end else begin
                        n_st.acc = wide[aip_pkg::VALUE_W-1:0];
                    end
                end
                n_stop     = pos_inc;
                n_st.phase = aip_pkg::PH_DIGITS;
            end else begin
                n_st.phase = aip_pkg::PH_DONE;
            end
        end

        if (bad) begin
            o_result.value      = '0;
            o_result.neg        = 1'b0;
            o_result.stop_index = '0;
            o_result.status     = aip_pkg::ST_BAD_BASE;
        end else if (n_st.ovf) begin
            o_result.value      = aip_pkg::ALL_ONES;
            o_result.neg        = 1'b0;
            o_result.stop_index = '0;
            o_result.status     = aip_pkg::ST_RANGE;
        end else begin
            o_result.value      = n_st.acc;
            o_result.neg        = n_st.neg;
            o_result.stop_index = aip_pkg::STOP_W'(n_stop);
            o_result.status     = aip_pkg::ST_OK;
        end

        // drop all string state once the last byte is taken
        if (i_last) begin
            o_state.phase = aip_pkg::PH_SPACE;
            o_state.acc   = '0;
            o_state.base  = '0;
            o_state.neg   = 1'b0;
            o_state.ovf   = 1'b0;
            o_pos         = '0;
            o_stop        = '0;
        end else begin
            o_state = n_st;
            o_pos   = pos_inc;
            o_stop  = n_stop;
        end
    end

endmodule

>>> rtl/ascii_integer_parser_u64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_u64
// Streaming ASCII to unsigned 64-bit integer parser, one byte per beat.
// A last byte's result goes from the input register to the result register.
// One byte per cycle unless a last byte waits on an untaken result; the rate
// is set by the 64 x 6 multiply plus digit add before the parse state registers.
// Reset: clears parse state, input and output valids; number base resets to 0.
// ----------------------------------------------------------------------------
module ascii_integer_parser_u64 #(
    parameter int unsigned INDEX_BITS = aip_pkg::INDEX_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    aip_char_if.sink    i_char,
    aip_cfg_if.sink     i_cfg,
    aip_res_if.source   o_res
);

    localparam int unsigned POS_W = (INDEX_BITS < aip_pkg::STOP_W) ? INDEX_BITS
                                                                   : aip_pkg::STOP_W;

    logic [aip_pkg::BASE_W-1:0]  r_cfg_base;
    logic                        r_in_valid;
    logic [aip_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_last;
    aip_pkg::t_pstate            r_state;
    aip_pkg::t_pstate            n_state;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;
    logic [POS_W-1:0]            r_stop;
    logic [POS_W-1:0]            n_stop;
    aip_pkg::t_result            n_result;
    aip_pkg::t_result            r_result;
    logic                        r_out_valid;
    logic                        advance;

    assign advance      = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_char.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    aip_step #(
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .i_cfg_base (r_cfg_base),
        .i_state    (r_state),
        .i_pos      (r_pos),
        .i_stop     (r_stop),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .o_state    (n_state),
        .o_pos      (n_pos),
        .o_stop     (n_stop),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= '0;
        end else if (i_cfg.valid) begin
            r_cfg_base <= i_cfg.number_base;
        end
    end

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.is_last;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= aip_pkg::PH_SPACE;
            r_state.acc   <= '0;
            r_state.base  <= '0;
            r_state.neg   <= 1'b0;
            r_state.ovf   <= 1'b0;
            r_pos         <= '0;
            r_stop        <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_stop  <= n_stop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_result.neg ? (aip_pkg::VALUE_W'(0) - r_result.value)
                                           : r_result.value;
    assign o_res.stop_index = r_result.stop_index;
    assign o_res.status     = r_result.status;

endmodule
